// ===== hw/rtl/sts_pkg.sv =====
`default_nettype none
package sts_pkg;

  typedef enum logic [4:0] {
    M_IDLE, M_CMT, M_CMTQ, M_IDENT, M_KWCOLON, M_KWSWORD, M_KWSCOLON, M_COLON,
    M_CVAR, M_BIN, M_STR, M_STRQ, M_DOLLAR, M_MINUS, M_INT10, M_RSIGN,
    M_RFIRST, M_RINT, M_DOT, M_FRAC, M_ESIGN, M_EFIRST, M_EXP
  } mode_e;

  localparam logic [4:0] K_TEXT     = 5'd0;
  localparam logic [4:0] K_END      = 5'd1;
  localparam logic [4:0] K_IDENT    = 5'd2;
  localparam logic [4:0] K_KEYWORD  = 5'd3;
  localparam logic [4:0] K_KEYWORDS = 5'd4;
  localparam logic [4:0] K_COLONVAR = 5'd5;
  localparam logic [4:0] K_BINSEL   = 5'd6;
  localparam logic [4:0] K_ASSIGN   = 5'd7;
  localparam logic [4:0] K_STRING   = 5'd8;
  localparam logic [4:0] K_CHAR     = 5'd9;
  localparam logic [4:0] K_INT      = 5'd10;
  localparam logic [4:0] K_FLOAT    = 5'd11;
  localparam logic [4:0] K_LPAREN   = 5'd12;
  localparam logic [4:0] K_RPAREN   = 5'd13;
  localparam logic [4:0] K_LBRACK   = 5'd14;
  localparam logic [4:0] K_RBRACK   = 5'd15;
  localparam logic [4:0] K_PERIOD   = 5'd16;
  localparam logic [4:0] K_SEMI     = 5'd17;
  localparam logic [4:0] K_CARET    = 5'd18;
  localparam logic [4:0] K_HASH     = 5'd19;

  localparam logic [3:0] E_NONE     = 4'd0;
  localparam logic [3:0] E_COMMENT  = 4'd1;
  localparam logic [3:0] E_KWCOLON  = 4'd2;
  localparam logic [3:0] E_CVAR     = 4'd3;
  localparam logic [3:0] E_NEGBASE  = 4'd4;
  localparam logic [3:0] E_BASE     = 4'd5;
  localparam logic [3:0] E_DIGIT    = 4'd6;
  localparam logic [3:0] E_EXPONENT = 4'd7;
  localparam logic [3:0] E_ILLEGAL  = 4'd8;
  localparam logic [3:0] E_STRING   = 4'd9;
  localparam logic [3:0] E_TOOLONG  = 4'd10;

  localparam logic [5:0]  BASE_TEN  = 6'd10;
  localparam logic [5:0]  NO_DIGIT  = 6'd63;
  localparam logic [19:0] LINE_MAX  = 20'hFFFFF;
  localparam logic [31:0] EXP_POS_MAX = 32'h7FFFFFFF;
  localparam logic [35:0] EXP_SAT   = 36'h080000000;

  typedef struct packed {
    logic       alpha;
    logic       digit;
    logic       special;
    logic [5:0] dval;
  } cls_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    cls_t       cls;
  } head_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  ch;
    logic [63:0] val;
    logic [7:0]  frac;
    logic [31:0] ex;
    logic [5:0]  rad;
    logic [3:0]  err;
    logic [19:0] line;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sts_front.sv =====
`default_nettype none
module sts_front import sts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       pop_i,
  output head_t           head_o
);

  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic [7:0] ch_q [2];
  cls_t       cls_q [2];
  logic       push;
  cls_t       cls_in;

  always_comb begin
    cls_in.alpha = (char_code_i >= "a" && char_code_i <= "z") ||
                   (char_code_i >= "A" && char_code_i <= "Z");
    cls_in.digit = char_code_i >= "0" && char_code_i <= "9";
    case (char_code_i)
      "+", "/", "\\", "*", "~", "<", ">", "=", "@", "%", "|", "&", "?", "!", ",":
        cls_in.special = 1'b1;
      default: cls_in.special = 1'b0;
    endcase
    if (cls_in.digit) cls_in.dval = 6'(char_code_i - "0");
    else if (char_code_i >= "A" && char_code_i <= "Z") cls_in.dval = 6'(char_code_i - "A" + 8'd10);
    else cls_in.dval = NO_DIGIT;
  end

  assign in_stall_o = cnt_q == 2'd2;
  assign push = in_valid_i && !in_stall_o;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ch_q[wp_q]  <= char_code_i;
      cls_q[wp_q] <= cls_in;
    end
  end

  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.ch    = ch_q[rp_q];
  assign head_o.cls   = cls_q[rp_q];

endmodule
`default_nettype wire

// ===== hw/rtl/sts_back.sv =====
`default_nettype none
module sts_back import sts_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  head_t      head_i,
  output logic       pop_o,
  input  wire logic  out_stall_i,
  output logic       out_valid_o,
  output res_t       out_res_o
);

  localparam int TLW = $clog2(MAX_TOKEN_CHARS);
  localparam logic [TLW:0] TL_LIMIT = (TLW + 1)'(MAX_TOKEN_CHARS);

  mode_e          mode_q, mode_d;
  logic [63:0]    acc_q, acc_d;
  logic [31:0]    eacc_q, eacc_d;
  logic [7:0]     frac_q, frac_d;
  logic [5:0]     base_q, base_d;
  logic [1:0]     neg_q, neg_d;
  logic [7:0]     held_q, held_d;
  logic [TLW-1:0] tl_q, tl_d;
  logic [19:0]    line_q, line_d;
  logic           halt_q, halt_d;
  logic [1:0]     idx_q;
  logic           ovalid_q;
  res_t           ores_q;

  res_t [3:0]     rl;
  logic [2:0]     n;
  logic           can_load, fire, done;

  function automatic res_t mk(input logic [4:0] k, input logic [7:0] c,
                              input logic [3:0] e, input logic [19:0] ln);
    res_t r;
    r = '0;
    r.kind = k;
    r.ch   = c;
    r.err  = e;
    r.line = ln;
    return r;
  endfunction

  function automatic void put(inout res_t [3:0] rr, inout logic [2:0] nn,
                              input logic h, input res_t x);
    if (!h && nn < 3'd4) begin
      rr[nn[1:0]] = x;
      nn = nn + 3'd1;
    end
  endfunction

  function automatic void fail(inout res_t [3:0] rr, inout logic [2:0] nn,
                               inout logic h, input logic [3:0] e,
                               input logic [19:0] ln);
    put(rr, nn, h, mk(K_END, 8'd0, e, ln));
    h = 1'b1;
  endfunction

  function automatic void text(inout res_t [3:0] rr, inout logic [2:0] nn,
                               inout logic h, inout logic [TLW-1:0] tl,
                               input logic [7:0] c, input logic [19:0] ln);
    if ({1'b0, tl} + 1'b1 >= TL_LIMIT) begin
      fail(rr, nn, h, E_TOOLONG, ln);
    end else begin
      tl = tl + 1'b1;
      put(rr, nn, h, mk(K_TEXT, c, E_NONE, ln));
    end
  endfunction

  function automatic res_t num(input logic flt, input logic [63:0] a,
                               input logic [31:0] ea, input logic [7:0] fr,
                               input logic [5:0] b, input logic [1:0] ng,
                               input logic [19:0] ln);
    res_t r;
    r = mk(flt ? K_FLOAT : K_INT, 8'd0, E_NONE, ln);
    r.val = ng[0] ? 64'd0 - a : a;
    r.rad = b;
    if (flt) begin
      r.frac = fr;
      if (ng[1]) r.ex = 32'd0 - ea;
      else r.ex = (ea > EXP_POS_MAX) ? EXP_POS_MAX : ea;
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0]  c;
    cls_t        k;
    logic        redo, dok;
    logic [35:0] et;
    c = head_i.ch;
    k = head_i.cls;
    mode_d = mode_q; acc_d = acc_q; eacc_d = eacc_q; frac_d = frac_q;
    base_d = base_q; neg_d = neg_q; held_d = held_q; tl_d = tl_q;
    line_d = line_q; halt_d = halt_q;
    rl = '0;
    n = '0;
    redo = 1'b1;
    et = '0;
    for (int p = 0; p < 2; p++) begin
      dok = k.dval < base_d;
      if (redo && !halt_d) begin
        redo = 1'b0;
        unique case (mode_d)
          M_CMT: begin
            if (c == 8'd0) fail(rl, n, halt_d, E_COMMENT, line_d);
            else if (c == "\n") begin
              if (line_d != LINE_MAX) line_d = line_d + 20'd1;
            end else if (c == "\"") mode_d = M_CMTQ;
          end
          M_CMTQ: begin
            if (c == "\"") mode_d = M_CMT;
            else begin mode_d = M_IDLE; redo = 1'b1; end
          end
          M_IDENT: begin
            if (k.alpha || k.digit) text(rl, n, halt_d, tl_d, c, line_d);
            else if (c == ":") begin
              text(rl, n, halt_d, tl_d, c, line_d); mode_d = M_KWCOLON;
            end else begin
              put(rl, n, halt_d, mk(K_IDENT, 8'd0, E_NONE, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_KWCOLON, M_KWSCOLON: begin
            if (k.alpha) begin
              text(rl, n, halt_d, tl_d, c, line_d); mode_d = M_KWSWORD;
            end else begin
              put(rl, n, halt_d, mk((mode_d == M_KWCOLON) ? K_KEYWORD : K_KEYWORDS,
                                    8'd0, E_NONE, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_KWSWORD: begin
            if (k.alpha || k.digit) text(rl, n, halt_d, tl_d, c, line_d);
            else if (c == ":") begin
              text(rl, n, halt_d, tl_d, c, line_d); mode_d = M_KWSCOLON;
            end else fail(rl, n, halt_d, E_KWCOLON, line_d);
          end
          M_COLON: begin
            if (k.alpha) begin
              text(rl, n, halt_d, tl_d, c, line_d); mode_d = M_CVAR;
            end else fail(rl, n, halt_d, E_CVAR, line_d);
          end
          M_CVAR: begin
            if (k.alpha || k.digit) text(rl, n, halt_d, tl_d, c, line_d);
            else begin
              put(rl, n, halt_d, mk(K_COLONVAR, 8'd0, E_NONE, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_BIN: begin
            mode_d = M_IDLE;
            if (held_d == "<" && c == "-") begin
              put(rl, n, halt_d, mk(K_ASSIGN, 8'd0, E_NONE, line_d));
            end else begin
              text(rl, n, halt_d, tl_d, held_d, line_d);
              if (k.special) text(rl, n, halt_d, tl_d, c, line_d);
              else redo = 1'b1;
              put(rl, n, halt_d, mk(K_BINSEL, 8'd0, E_NONE, line_d));
            end
          end
          M_STR: begin
            if (c == 8'd0) fail(rl, n, halt_d, E_STRING, line_d);
            else if (c == "'") mode_d = M_STRQ;
            else begin
              if (c == "\n" && line_d != LINE_MAX) line_d = line_d + 20'd1;
              text(rl, n, halt_d, tl_d, c, line_d);
            end
          end
          M_STRQ: begin
            if (c == "'") begin
              text(rl, n, halt_d, tl_d, c, line_d); mode_d = M_STR;
            end else begin
              put(rl, n, halt_d, mk(K_STRING, 8'd0, E_NONE, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_DOLLAR: begin
            put(rl, n, halt_d, mk(K_CHAR, c, E_NONE, line_d));
            mode_d = M_IDLE;
            redo = c == 8'd0;
          end
          M_MINUS: begin
            if (k.digit) begin
              acc_d = {58'd0, k.dval}; neg_d = 2'd1; mode_d = M_INT10;
            end else begin
              text(rl, n, halt_d, tl_d, "-", line_d);
              put(rl, n, halt_d, mk(K_BINSEL, 8'd0, E_NONE, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_INT10: begin
            if (k.digit) acc_d = acc_d * 64'd10 + {58'd0, k.dval};
            else if (c == "r") begin
              if (neg_d[0]) fail(rl, n, halt_d, E_NEGBASE, line_d);
              else if (acc_d < 64'd2 || acc_d > 64'd36) fail(rl, n, halt_d, E_BASE, line_d);
              else begin
                base_d = acc_d[5:0]; acc_d = '0; neg_d = '0; mode_d = M_RSIGN;
              end
            end else if (c == ".") mode_d = M_DOT;
            else if (c == "e") mode_d = M_ESIGN;
            else begin
              put(rl, n, halt_d, num(1'b0, acc_d, eacc_d, frac_d, base_d, neg_d, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_RSIGN: begin
            mode_d = M_RFIRST;
            if (c == "-") neg_d[0] = 1'b1;
            else redo = 1'b1;
          end
          M_RFIRST: begin
            if (dok) begin acc_d = {58'd0, k.dval}; mode_d = M_RINT; end
            else fail(rl, n, halt_d, E_DIGIT, line_d);
          end
          M_RINT: begin
            if (dok) acc_d = acc_d * {58'd0, base_d} + {58'd0, k.dval};
            else if (c == ".") mode_d = M_DOT;
            else if (c == "e") mode_d = M_ESIGN;
            else begin
              put(rl, n, halt_d, num(1'b0, acc_d, eacc_d, frac_d, base_d, neg_d, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_DOT: begin
            if (dok) begin
              acc_d = acc_d * {58'd0, base_d} + {58'd0, k.dval};
              frac_d = 8'd1; mode_d = M_FRAC;
            end else begin
              put(rl, n, halt_d, num(1'b0, acc_d, eacc_d, frac_d, base_d, neg_d, line_d));
              put(rl, n, halt_d, mk(K_PERIOD, 8'd0, E_NONE, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_FRAC: begin
            if (dok) begin
              acc_d = acc_d * {58'd0, base_d} + {58'd0, k.dval};
              if (frac_d != 8'd255) frac_d = frac_d + 8'd1;
            end else if (c == "e") mode_d = M_ESIGN;
            else begin
              put(rl, n, halt_d, num(1'b1, acc_d, eacc_d, frac_d, base_d, neg_d, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          M_ESIGN: begin
            mode_d = M_EFIRST;
            if (c == "-") neg_d[1] = 1'b1;
            else redo = 1'b1;
          end
          M_EFIRST: begin
            if (k.digit) begin eacc_d = {26'd0, k.dval}; mode_d = M_EXP; end
            else fail(rl, n, halt_d, E_EXPONENT, line_d);
          end
          M_EXP: begin
            if (k.digit) begin
              et = {4'd0, eacc_d} * 36'd10 + {30'd0, k.dval};
              eacc_d = (et > EXP_SAT) ? EXP_SAT[31:0] : et[31:0];
            end else begin
              put(rl, n, halt_d, num(1'b1, acc_d, eacc_d, frac_d, base_d, neg_d, line_d));
              mode_d = M_IDLE; redo = 1'b1;
            end
          end
          default: begin
            mode_d = M_IDLE;
            tl_d = '0;
            case (c)
              " ", "\t", "\r": ;
              "\n": if (line_d != LINE_MAX) line_d = line_d + 20'd1;
              "\"": mode_d = M_CMT;
              8'd0: put(rl, n, halt_d, mk(K_END, 8'd0, E_NONE, line_d));
              ":":  mode_d = M_COLON;
              "'":  mode_d = M_STR;
              "$":  mode_d = M_DOLLAR;
              "-": begin
                acc_d = '0; eacc_d = '0; frac_d = '0; base_d = BASE_TEN; neg_d = '0;
                mode_d = M_MINUS;
              end
              "(": put(rl, n, halt_d, mk(K_LPAREN, 8'd0, E_NONE, line_d));
              ")": put(rl, n, halt_d, mk(K_RPAREN, 8'd0, E_NONE, line_d));
              "[": put(rl, n, halt_d, mk(K_LBRACK, 8'd0, E_NONE, line_d));
              "]": put(rl, n, halt_d, mk(K_RBRACK, 8'd0, E_NONE, line_d));
              ".": put(rl, n, halt_d, mk(K_PERIOD, 8'd0, E_NONE, line_d));
              ";": put(rl, n, halt_d, mk(K_SEMI, 8'd0, E_NONE, line_d));
              "^": put(rl, n, halt_d, mk(K_CARET, 8'd0, E_NONE, line_d));
              "#": put(rl, n, halt_d, mk(K_HASH, 8'd0, E_NONE, line_d));
              default: begin
                if (k.alpha) begin
                  text(rl, n, halt_d, tl_d, c, line_d); mode_d = M_IDENT;
                end else if (k.special) begin
                  held_d = c; mode_d = M_BIN;
                end else if (k.digit) begin
                  acc_d = {58'd0, k.dval}; eacc_d = '0; frac_d = '0;
                  base_d = BASE_TEN; neg_d = '0; mode_d = M_INT10;
                end else fail(rl, n, halt_d, E_ILLEGAL, line_d);
              end
            endcase
          end
        endcase
      end
    end
  end

  assign can_load = !ovalid_q || !out_stall_i;
  assign fire     = head_i.valid && can_load;
  assign done     = (n == 3'd0) || ({1'b0, idx_q} == n - 3'd1);
  assign pop_o    = fire && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      acc_q    <= '0;
      eacc_q   <= '0;
      frac_q   <= '0;
      base_q   <= BASE_TEN;
      neg_q    <= '0;
      held_q   <= '0;
      tl_q     <= '0;
      line_q   <= '0;
      halt_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q <= mode_d; acc_q <= acc_d; eacc_q <= eacc_d; frac_q <= frac_d;
        base_q <= base_d; neg_q <= neg_d; held_q <= held_d; tl_q <= tl_d;
        line_q <= line_d; halt_q <= halt_d;
        idx_q  <= '0;
      end else if (fire) begin
        idx_q <= idx_q + 2'd1;
      end
      if (can_load) ovalid_q <= fire && n != 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && n != 3'd0) begin
      ores_q <= {rl[idx_q][$bits(res_t)-1:1], done};
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_res_o   = ores_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag dropped");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> idx_q == 2'd0) else $error("results pending after halt");
  a_idx_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> head_i.valid) else $error("result index without head");
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ores_q.err != E_NONE) |-> halt_q) else $error("error without halt");

endmodule
`default_nettype wire

// ===== hw/rtl/smalltalk_token_scanner_unit.sv =====
// A character is registered in the queue, its first result beat in the output
// register. One character per cycle while the output is not stalled; one that
// causes k results holds the scanner until its beats enter the output register.
// A 2-entry character queue separates the front from the scanner.
// Reset (rst_ni low, asynchronous): idle scanner, line 0, queue empty, no error.
`default_nettype none
module smalltalk_token_scanner_unit import sts_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         char_code_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [4:0]              token_kind_o,
  output logic [7:0]              text_char_o,
  output logic signed [63:0]      number_value_o,
  output logic [7:0]              fraction_digits_o,
  output logic signed [31:0]      exponent_value_o,
  output logic [5:0]              radix_o,
  output logic [3:0]              error_code_o,
  output logic [19:0]             line_number_o,
  output logic                    last_result_o
);

  head_t head;
  logic  pop;
  res_t  res;

  sts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .pop_i       (pop),
    .head_o      (head)
  );

  sts_back #(.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (res)
  );

  assign token_kind_o      = res.kind;
  assign text_char_o       = res.ch;
  assign number_value_o    = res.val;
  assign fraction_digits_o = res.frac;
  assign exponent_value_o  = res.ex;
  assign radix_o           = res.rad;
  assign error_code_o      = res.err;
  assign line_number_o     = res.line;
  assign last_result_o     = res.last;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sts_pkg::*;

  localparam int TOKEN_CAP = 32;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] char_code;
  logic out_valid;
  logic out_stall;
  logic [4:0] token_kind;
  logic [7:0] text_char;
  logic signed [63:0] number_value;
  logic [7:0] fraction_digits;
  logic signed [31:0] exponent_value;
  logic [5:0] radix;
  logic [3:0] error_code;
  logic [19:0] line_number;
  logic last_result;

  smalltalk_token_scanner_unit #(.MAX_TOKEN_CHARS(TOKEN_CAP)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .char_code_i(char_code),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .token_kind_o(token_kind), .text_char_o(text_char), .number_value_o(number_value),
    .fraction_digits_o(fraction_digits), .exponent_value_o(exponent_value),
    .radix_o(radix), .error_code_o(error_code), .line_number_o(line_number),
    .last_result_o(last_result)
  );

  // scanner prediction state
  mode_e       mode;
  logic [63:0] mant_acc;
  logic [31:0] exp_acc;
  logic [7:0]  frac_cnt;
  logic [5:0]  num_base;
  logic [1:0]  neg_bits;
  logic [7:0]  held_ch;
  int          tok_len;
  logic [19:0] line_cnt;
  bit          halted;

  res_t step_beats[$];
  res_t expected_beats[$];
  logic [7:0] src[$];

  int errors = 0;
  int chars_sent = 0;
  int beats_checked = 0;
  int burst_left = 0;
  bit sender_gaps = 1;
  int stall_mode = 0;
  bit hold_req = 0;
  int hold_left = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_special(logic [7:0] c);
    return c inside {"+", "/", "\\", "*", "~", "<", ">", "=", "@", "%", "|", "&", "?",
                     "!", ","};
  endfunction

  function automatic int digit_val(logic [7:0] c, logic [5:0] b);
    int v;
    if (is_digit(c)) v = c - "0";
    else if (c >= "A" && c <= "Z") v = c - "A" + 10;
    else return -1;
    return (v < b) ? v : -1;
  endfunction

  function automatic void put_beat(logic [4:0] k, logic [7:0] ch, logic [63:0] v,
                                   logic [7:0] fr, logic [31:0] ex, logic [5:0] rad,
                                   logic [3:0] err);
    res_t r;
    if (halted || step_beats.size() >= 4) return;
    r.kind = k; r.ch = ch; r.val = v; r.frac = fr; r.ex = ex;
    r.rad = rad; r.err = err; r.line = line_cnt; r.last = 1'b0;
    step_beats.push_back(r);
  endfunction

  function automatic void raise_error(logic [3:0] e);
    put_beat(K_END, 0, 0, 0, 0, 0, e);
    halted = 1;
  endfunction

  function automatic void add_text(logic [7:0] c);
    if (tok_len + 1 >= TOKEN_CAP) begin
      raise_error(E_TOOLONG);
      return;
    end
    tok_len++;
    put_beat(K_TEXT, c, 0, 0, 0, 0, E_NONE);
  endfunction

  function automatic void next_line();
    if (line_cnt != LINE_MAX) line_cnt++;
  endfunction

  function automatic logic [63:0] signed_mant();
    return neg_bits[0] ? 64'd0 - mant_acc : mant_acc;
  endfunction

  function automatic void emit_int();
    put_beat(K_INT, 0, signed_mant(), 0, 0, num_base, E_NONE);
  endfunction

  function automatic void emit_float();
    logic [31:0] ex;
    if (neg_bits[1]) ex = 32'd0 - exp_acc;
    else ex = (exp_acc > EXP_POS_MAX) ? EXP_POS_MAX : exp_acc;
    put_beat(K_FLOAT, 0, signed_mant(), frac_cnt, ex, num_base, E_NONE);
  endfunction

  function automatic void start_number(logic [1:0] n);
    mant_acc = 0; exp_acc = 0; frac_cnt = 0; num_base = BASE_TEN; neg_bits = n;
  endfunction

  function automatic void scan_idle(logic [7:0] c);
    tok_len = 0;
    case (c)
      " ", 8'h09, 8'h0D: ;
      8'h0A: next_line();
      "\"": mode = M_CMT;
      8'h00: put_beat(K_END, 0, 0, 0, 0, 0, E_NONE);
      ":": mode = M_COLON;
      "'": mode = M_STR;
      "$": mode = M_DOLLAR;
      "-": begin start_number(0); mode = M_MINUS; end
      "(": put_beat(K_LPAREN, 0, 0, 0, 0, 0, E_NONE);
      ")": put_beat(K_RPAREN, 0, 0, 0, 0, 0, E_NONE);
      "[": put_beat(K_LBRACK, 0, 0, 0, 0, 0, E_NONE);
      "]": put_beat(K_RBRACK, 0, 0, 0, 0, 0, E_NONE);
      ".": put_beat(K_PERIOD, 0, 0, 0, 0, 0, E_NONE);
      ";": put_beat(K_SEMI, 0, 0, 0, 0, 0, E_NONE);
      "^": put_beat(K_CARET, 0, 0, 0, 0, 0, E_NONE);
      "#": put_beat(K_HASH, 0, 0, 0, 0, 0, E_NONE);
      default: begin
        if (is_alpha(c)) begin add_text(c); mode = M_IDENT; end
        else if (is_special(c)) begin held_ch = c; mode = M_BIN; end
        else if (is_digit(c)) begin
          start_number(0); mant_acc = c - "0"; mode = M_INT10;
        end else raise_error(E_ILLEGAL);
      end
    endcase
  endfunction

  function automatic void scan_char(logic [7:0] c);
    bit redo;
    int d;
    logic [63:0] t;
    step_beats.delete();
    if (halted) return;
    redo = 1;
    while (redo && !halted) begin
      redo = 0;
      case (mode)
        M_CMT: begin
          if (c == 0) raise_error(E_COMMENT);
          else if (c == 8'h0A) next_line();
          else if (c == "\"") mode = M_CMTQ;
        end
        M_CMTQ: if (c == "\"") mode = M_CMT; else begin mode = M_IDLE; redo = 1; end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) add_text(c);
          else if (c == ":") begin add_text(c); mode = M_KWCOLON; end
          else begin put_beat(K_IDENT, 0, 0, 0, 0, 0, E_NONE); mode = M_IDLE; redo = 1; end
        end
        M_KWCOLON: begin
          if (is_alpha(c)) begin add_text(c); mode = M_KWSWORD; end
          else begin put_beat(K_KEYWORD, 0, 0, 0, 0, 0, E_NONE); mode = M_IDLE; redo = 1; end
        end
        M_KWSWORD: begin
          if (is_alpha(c) || is_digit(c)) add_text(c);
          else if (c == ":") begin add_text(c); mode = M_KWSCOLON; end
          else raise_error(E_KWCOLON);
        end
        M_KWSCOLON: begin
          if (is_alpha(c)) begin add_text(c); mode = M_KWSWORD; end
          else begin put_beat(K_KEYWORDS, 0, 0, 0, 0, 0, E_NONE); mode = M_IDLE; redo = 1; end
        end
        M_COLON: if (is_alpha(c)) begin add_text(c); mode = M_CVAR; end
                 else raise_error(E_CVAR);
        M_CVAR: begin
          if (is_alpha(c) || is_digit(c)) add_text(c);
          else begin put_beat(K_COLONVAR, 0, 0, 0, 0, 0, E_NONE); mode = M_IDLE; redo = 1; end
        end
        M_BIN: begin
          if (held_ch == "<" && c == "-") begin
            put_beat(K_ASSIGN, 0, 0, 0, 0, 0, E_NONE); mode = M_IDLE;
          end else if (is_special(c)) begin
            add_text(held_ch); add_text(c);
            put_beat(K_BINSEL, 0, 0, 0, 0, 0, E_NONE); mode = M_IDLE;
          end else begin
            add_text(held_ch);
            put_beat(K_BINSEL, 0, 0, 0, 0, 0, E_NONE); mode = M_IDLE; redo = 1;
          end
        end
        M_STR: begin
          if (c == 0) raise_error(E_STRING);
          else if (c == "'") mode = M_STRQ;
          else begin if (c == 8'h0A) next_line(); add_text(c); end
        end
        M_STRQ: begin
          if (c == "'") begin add_text(c); mode = M_STR; end
          else begin put_beat(K_STRING, 0, 0, 0, 0, 0, E_NONE); mode = M_IDLE; redo = 1; end
        end
        M_DOLLAR: begin
          put_beat(K_CHAR, c, 0, 0, 0, 0, E_NONE);
          mode = M_IDLE;
          if (c == 0) redo = 1;
        end
        M_MINUS: begin
          if (is_digit(c)) begin mant_acc = c - "0"; neg_bits = 1; mode = M_INT10; end
          else begin
            add_text("-"); put_beat(K_BINSEL, 0, 0, 0, 0, 0, E_NONE);
            mode = M_IDLE; redo = 1;
          end
        end
        M_INT10: begin
          if (is_digit(c)) mant_acc = mant_acc * 10 + (c - "0");
          else if (c == "r") begin
            if (neg_bits[0]) raise_error(E_NEGBASE);
            else if (mant_acc < 2 || mant_acc > 36) raise_error(E_BASE);
            else begin
              num_base = mant_acc[5:0]; mant_acc = 0; neg_bits = 0; mode = M_RSIGN;
            end
          end else if (c == ".") mode = M_DOT;
          else if (c == "e") mode = M_ESIGN;
          else begin emit_int(); mode = M_IDLE; redo = 1; end
        end
        M_RSIGN: begin
          if (c == "-") begin neg_bits[0] = 1; mode = M_RFIRST; end
          else begin mode = M_RFIRST; redo = 1; end
        end
        M_RFIRST: begin
          d = digit_val(c, num_base);
          if (d >= 0) begin mant_acc = d; mode = M_RINT; end
          else raise_error(E_DIGIT);
        end
        M_RINT: begin
          d = digit_val(c, num_base);
          if (d >= 0) mant_acc = mant_acc * num_base + d;
          else if (c == ".") mode = M_DOT;
          else if (c == "e") mode = M_ESIGN;
          else begin emit_int(); mode = M_IDLE; redo = 1; end
        end
        M_DOT: begin
          d = digit_val(c, num_base);
          if (d >= 0) begin
            mant_acc = mant_acc * num_base + d; frac_cnt = 1; mode = M_FRAC;
          end else begin
            emit_int(); put_beat(K_PERIOD, 0, 0, 0, 0, 0, E_NONE);
            mode = M_IDLE; redo = 1;
          end
        end
        M_FRAC: begin
          d = digit_val(c, num_base);
          if (d >= 0) begin
            mant_acc = mant_acc * num_base + d;
            if (frac_cnt != 8'd255) frac_cnt++;
          end else if (c == "e") mode = M_ESIGN;
          else begin emit_float(); mode = M_IDLE; redo = 1; end
        end
        M_ESIGN: begin
          if (c == "-") begin neg_bits[1] = 1; mode = M_EFIRST; end
          else begin mode = M_EFIRST; redo = 1; end
        end
        M_EFIRST: begin
          if (is_digit(c)) begin exp_acc = c - "0"; mode = M_EXP; end
          else raise_error(E_EXPONENT);
        end
        M_EXP: begin
          if (is_digit(c)) begin
            t = {32'd0, exp_acc} * 10 + (c - "0");
            exp_acc = (t > 64'h80000000) ? 32'h80000000 : t[31:0];
          end else begin emit_float(); mode = M_IDLE; redo = 1; end
        end
        default: begin mode = M_IDLE; scan_idle(c); end
      endcase
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // receiver: checks beats and drives its stall pattern
  always @(posedge clk) begin
    res_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) report_mismatch("beat with nothing expected");
      else begin
        r = expected_beats.pop_front();
        beats_checked++;
        if (token_kind != r.kind)
          report_mismatch($sformatf("kind %0d want %0d", token_kind, r.kind));
        if (text_char != r.ch)
          report_mismatch($sformatf("text_char %0h want %0h", text_char, r.ch));
        if (number_value != r.val)
          report_mismatch($sformatf("value %0h want %0h", number_value, r.val));
        if (fraction_digits != r.frac)
          report_mismatch($sformatf("frac %0d want %0d", fraction_digits, r.frac));
        if (exponent_value != r.ex)
          report_mismatch($sformatf("exponent %0h want %0h", exponent_value, r.ex));
        if (radix != r.rad)
          report_mismatch($sformatf("radix %0d want %0d", radix, r.rad));
        if (error_code != r.err)
          report_mismatch($sformatf("error %0d want %0d", error_code, r.err));
        if (line_number != r.line)
          report_mismatch($sformatf("line %0d want %0d", line_number, r.line));
        if (last_result != r.last)
          report_mismatch($sformatf("last %0d want %0d", last_result, r.last));
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = 300;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  task automatic send_char(logic [7:0] c);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    scan_char(c);
    in_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic flush_src();
    while (src.size() > 0) send_char(src.pop_front());
  endtask

  function automatic void push_str(string s);
    foreach (s[i]) src.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_base_digit(int b);
    int v;
    v = $urandom_range(0, b - 1);
    return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
  endfunction

  function automatic void push_word();
    src.push_back(rand_letter());
    repeat ($urandom_range(0, 7))
      src.push_back($urandom_range(0, 2) ? rand_letter() : 8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void push_number();
    int b;
    b = 10;
    if ($urandom_range(0, 2) == 0) begin
      b = $urandom_range(2, 36);
      push_str($sformatf("%0dr", b));
      if ($urandom_range(0, 3) == 0) src.push_back("-");
    end else if ($urandom_range(0, 3) == 0) src.push_back("-");
    repeat ($urandom_range(1, $urandom_range(0, 5) == 0 ? 24 : 6))
      src.push_back(rand_base_digit(b));
    if ($urandom_range(0, 2) == 0) begin
      src.push_back(".");
      repeat ($urandom_range(1, 6)) src.push_back(rand_base_digit(b));
    end
    if ($urandom_range(0, 3) == 0) begin
      src.push_back("e");
      if ($urandom_range(0, 1)) src.push_back("-");
      repeat ($urandom_range(1, $urandom_range(0, 5) == 0 ? 14 : 3))
        src.push_back(8'("0" + $urandom_range(0, 9)));
    end
  endfunction

  function automatic logic [7:0] rand_body_byte(logic [7:0] quote);
    logic [7:0] c;
    do c = $urandom_range(0, 3) == 0 ? 8'($urandom_range(128, 255))
                                     : 8'($urandom_range(1, 127));
    while (c == quote);
    return c;
  endfunction

  function automatic void push_token();
    string punct;
    punct = "()[].;^#";
    case ($urandom_range(0, 13))
      0: push_word();
      1: begin push_word(); src.push_back(":"); end
      2: repeat ($urandom_range(2, 3)) begin push_word(); src.push_back(":"); end
      3: begin src.push_back(":"); push_word(); end
      4: begin
        src.push_back(8'($urandom_range(0, 1) ? "<" : "*"));
        src.push_back($urandom_range(0, 1) ? 8'("-") : 8'("="));
      end
      5: begin
        src.push_back("'");
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 5) == 0) push_str("''");
          else src.push_back(rand_body_byte("'"));
        end
        src.push_back("'");
      end
      6: begin src.push_back("$"); src.push_back(8'($urandom_range(0, 255))); end
      7, 8, 9: push_number();
      10: begin
        src.push_back("\"");
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 5) == 0) push_str("\"\"");
          else src.push_back(rand_body_byte("\""));
        end
        src.push_back("\"");
      end
      11: src.push_back(punct[$urandom_range(0, 7)]);
      12: src.push_back(8'h0A);
      default: src.push_back(8'h00);
    endcase
    src.push_back($urandom_range(0, 4) == 0 ? 8'h09 : 8'h20);
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    stall_mode = 0;
    sender_gaps = 0;
    push_str("x Abc9 at: at:put: :v1 + <= <- - +x 'it''s' $a $$ $");
    src.push_back(8'h0A);
    push_str(" ( ) [ ] . ; ^ # \"c\"\"q\" 42 -7 5. ");
    src.push_back(8'h0D);
    src.push_back(8'h00);
    flush_src();
    wait_drained();
  endtask

  task automatic test_numbers();
    stall_mode = 1;
    sender_gaps = 1;
    push_str("16rFF 2r-101 36rZZ.Z 3.25 1.5e-3 2e5 1e99999999999 1e-99999999999 ");
    push_str("99999999999999999999999 2r1.1e3 -0.5 1.");
    repeat (20) src.push_back("7");
    push_str(" 'x");
    src.push_back(8'hFF);
    push_str("' $");
    src.push_back(8'h00);
    flush_src();
    wait_drained();
  endtask

  task automatic test_random_text();
    int start;
    start = chars_sent;
    for (int phase = 0; phase < 3; phase++) begin
      stall_mode = phase;
      sender_gaps = (phase != 2);
      while (chars_sent - start < (phase + 1) * 15) begin
        push_token();
        flush_src();
      end
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    stall_mode = 0;
    sender_gaps = 0;
    hold_req = 1;
    repeat (6) push_token();
    push_str("at:put: 'abcdefgh' ");
    flush_src();
    wait_drained();
  endtask

  task automatic test_error_halt();
    int pick;
    stall_mode = 1;
    sender_gaps = 1;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin push_str("\"open"); src.push_back(8'h00); end
      1: push_str("a:b ");
      2: push_str(": ");
      3: push_str("-2r1 ");
      4: push_str("40r1 ");
      5: push_str("2r2 ");
      6: push_str("1ex ");
      7: src.push_back(8'h80);
      8: begin push_str("'open"); src.push_back(8'h00); end
      default: repeat (TOKEN_CAP) src.push_back("a");
    endcase
    repeat (8) src.push_back(8'($urandom_range(0, 255)));
    flush_src();
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    char_code = 8'h00;
    out_stall = 1'b0;
    mode = M_IDLE;
    mant_acc = 0; exp_acc = 0; frac_cnt = 0; num_base = BASE_TEN;
    neg_bits = 0; held_ch = 0; tok_len = 0; line_cnt = 0; halted = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_numbers();
    test_random_text();
    test_output_backpressure();
    test_error_halt();
    in_valid <= 1'b0;
    repeat (10) @(posedge clk);
    $display("Scanned %0d characters and checked %0d result beats over tokens, numbers,",
             chars_sent, beats_checked);
    $display("comments, output back-pressure and one halting error; %0d mismatches", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sts_pkg.sv
hw/rtl/sts_front.sv
hw/rtl/sts_back.sv
hw/rtl/smalltalk_token_scanner_unit.sv
dv/tb_top.sv
